@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the sequencer RTL.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/slbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbs_pkg
// Types and constants shared by the loop block sequencer.
// ----------------------------------------------------------------------------
package slbs_pkg;

  localparam int BLOCK_W    = 16;
  localparam int PASS_W     = 16;
  localparam int FRAME_W    = 24;
  localparam int BFRAME_W   = 13;
  localparam int END_W      = FRAME_W + 1;
  localparam int LIMIT_W    = PASS_W + 1;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 3;

  // Rounding division (2*f + d) / (2*d): numerator and divisor widths.
  localparam int NUM_W  = FRAME_W + 2;
  localparam int DEN_W  = BFRAME_W + 1;
  localparam int STEP_W = $clog2(NUM_W + 2);

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FRAMES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START_FRAME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_END_FRAME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_LIMIT       = 3'd4;

  localparam logic [1:0] OP_FETCH   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_SEEK    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [BLOCK_W-1:0] seek_block;
  } slbs_req_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] block_index;
    logic               block_valid;
    logic               play_done;
    logic [PASS_W-1:0]  loops_completed;
    logic               released_flag;
  } slbs_res_t;

  // Loop settings handed from the configuration unit to the core.
  typedef struct packed {
    logic [BLOCK_W-1:0] total;
    logic [BLOCK_W-1:0] first;
    logic [BLOCK_W-1:0] last;
    logic               limit_neg;
    logic [PASS_W-1:0]  limit;
    logic               busy;
  } loop_cfg_t;

endpackage

@@ rtl/slbs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbs_if
// Valid/ready channels for requests and results of the sequencer.
// ----------------------------------------------------------------------------
interface slbs_req_if import slbs_pkg::*; ();
  logic      valid;
  logic      ready;
  slbs_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface slbs_res_if import slbs_pkg::*; ();
  logic      valid;
  logic      ready;
  slbs_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/slbs_loop_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbs_loop_unit
// Configuration registers and loop point conversion from frames to blocks.
// Two restoring dividers run side by side, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slbs_loop_unit import slbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output loop_cfg_t             loop_cfg
);

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic             qbit;
  } div_step_t;

  logic [BLOCK_W-1:0]  total_blocks;
  logic [BFRAME_W-1:0] block_frames;
  logic [FRAME_W-1:0]  loop_start_frame;
  logic [END_W-1:0]    loop_end_frame;
  logic [LIMIT_W-1:0]  loop_limit;

  logic                busy;
  logic [STEP_W-1:0]   step_cnt;
  logic [NUM_W-1:0]    num_s, num_e;
  logic [NUM_W-1:0]    quo_s, quo_e;
  logic [DEN_W-1:0]    rem_s, rem_e;
  logic [DEN_W-1:0]    den;
  logic [BLOCK_W-1:0]  first, last;

  logic [BLOCK_W-1:0]  tot_eff;
  logic [BFRAME_W-1:0] bf_eff;
  logic                reg_write;
  div_step_t           step_s, step_e;
  logic [BLOCK_W-1:0]  first_next, last_next;
  logic [NUM_W-1:0]    tot_wide, tot_m1_wide;

  function automatic div_step_t div_step(input logic [DEN_W-1:0] rem,
                                         input logic             nbit,
                                         input logic [DEN_W-1:0] d);
    logic [DEN_W:0] sh;
    div_step_t      r;
    sh = {rem, nbit};
    if (sh >= {1'b0, d}) begin
      r.rem  = DEN_W'(sh - {1'b0, d});
      r.qbit = 1'b1;
    end else begin
      r.rem  = sh[DEN_W-1:0];
      r.qbit = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    tot_eff = (total_blocks == '0) ? BLOCK_W'(1) : total_blocks;
    bf_eff  = (block_frames == '0) ? BFRAME_W'(1) : block_frames;
    unique case (cfg_index)
      REG_TOTAL_BLOCKS, REG_BLOCK_FRAMES, REG_LOOP_START_FRAME,
      REG_LOOP_END_FRAME, REG_LOOP_LIMIT: reg_write = cfg_we;
      default: reg_write = 1'b0;
    endcase
  end

  assign step_s = div_step(rem_s, num_s[NUM_W-1], den);
  assign step_e = div_step(rem_e, num_e[NUM_W-1], den);

  // Clamp the rounded quotients against the sample length.
  always_comb begin
    tot_wide    = NUM_W'(tot_eff);
    tot_m1_wide = NUM_W'(tot_eff - 1'b1);
    first_next  = (quo_s > tot_m1_wide) ? tot_m1_wide[BLOCK_W-1:0] : quo_s[BLOCK_W-1:0];
    if (loop_end_frame[END_W-1]) begin
      last_next = tot_eff;
    end else if (quo_e == '0) begin
      last_next = BLOCK_W'(1);
    end else if (quo_e > tot_wide) begin
      last_next = tot_eff;
    end else begin
      last_next = quo_e[BLOCK_W-1:0];
    end
    if (last_next <= first_next) begin
      last_next = first_next + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks     <= BLOCK_W'(1);
      block_frames     <= BFRAME_W'(1);
      loop_start_frame <= '0;
      loop_end_frame   <= '1;
      loop_limit       <= '0;
      busy             <= 1'b0;
      step_cnt         <= '0;
      first            <= '0;
      last             <= BLOCK_W'(1);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TOTAL_BLOCKS:     total_blocks     <= cfg_data[BLOCK_W-1:0];
          REG_BLOCK_FRAMES:     block_frames     <= cfg_data[BFRAME_W-1:0];
          REG_LOOP_START_FRAME: loop_start_frame <= cfg_data[FRAME_W-1:0];
          REG_LOOP_END_FRAME:   loop_end_frame   <= cfg_data[END_W-1:0];
          REG_LOOP_LIMIT:       loop_limit       <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // A new write restarts the conversion with the updated registers.
      if (reg_write) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        if (step_cnt == STEP_W'(NUM_W + 1)) begin
          busy  <= 1'b0;
          first <= first_next;
          last  <= last_next;
        end else begin
          step_cnt <= step_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !reg_write) begin
      if (step_cnt == '0) begin
        num_s <= NUM_W'({loop_start_frame, 1'b0}) + NUM_W'(bf_eff);
        num_e <= NUM_W'({loop_end_frame[FRAME_W-1:0], 1'b0}) + NUM_W'(bf_eff);
        den   <= {bf_eff, 1'b0};
        rem_s <= '0;
        rem_e <= '0;
        quo_s <= '0;
        quo_e <= '0;
      end else if (step_cnt <= STEP_W'(NUM_W)) begin
        num_s <= {num_s[NUM_W-2:0], 1'b0};
        num_e <= {num_e[NUM_W-2:0], 1'b0};
        rem_s <= step_s.rem;
        rem_e <= step_e.rem;
        quo_s <= {quo_s[NUM_W-2:0], step_s.qbit};
        quo_e <= {quo_e[NUM_W-2:0], step_e.qbit};
      end
    end
  end

  always_comb begin
    loop_cfg.total     = tot_eff;
    loop_cfg.first     = first;
    loop_cfg.last      = last;
    loop_cfg.limit_neg = loop_limit[LIMIT_W-1];
    loop_cfg.limit     = loop_limit[PASS_W-1:0];
    loop_cfg.busy      = busy;
  end

  `ASSERT_NEXT(a_write_starts_conv, clk, rst, reg_write, busy)
  `ASSERT_IMPL(a_loop_span_ok, clk, rst, !busy, (last > first) && (last <= tot_eff))

endmodule

@@ rtl/slbs_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbs_core
// Request register, play position state and result register. Each request
// is resolved in the single cycle in which it moves into the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slbs_core import slbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  loop_cfg_t  loop_cfg,
  slbs_req_if.sink   req,
  slbs_res_if.source res
);

  logic               in_valid;
  slbs_req_t          in_item;
  logic               res_valid;
  slbs_res_t          res_item;

  logic [BLOCK_W-1:0] position;
  logic [PASS_W-1:0]  loop_passes;
  logic               released;

  logic               advance;
  logic               looping;
  logic               looping_next;
  logic               go;
  logic [BLOCK_W-1:0] position_next;
  logic [BLOCK_W-1:0] step_pos;
  logic [PASS_W-1:0]  loop_passes_next;
  logic               released_next;
  slbs_res_t          res_next;

  function automatic logic [PASS_W-1:0] sat_inc(input logic [PASS_W-1:0] x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  assign advance   = in_valid && (!res_valid || res.ready);
  assign req.ready = !loop_cfg.busy && (!in_valid || advance);
  assign res.valid   = res_valid;
  assign res.payload = res_item;

  always_comb begin
    position_next    = position;
    loop_passes_next = loop_passes;
    released_next    = released;
    step_pos         = '0;
    go               = 1'b0;
    res_next         = '0;
    looping = !released && (loop_cfg.limit_neg || loop_passes < loop_cfg.limit);
    case (in_item.opcode)
      OP_FETCH: begin
        if (looping) begin
          go = 1'b1;
          // At the loop end the pass is counted first; the last pass fetches nothing.
          if (position >= loop_cfg.last) begin
            position_next    = loop_cfg.first;
            loop_passes_next = sat_inc(loop_passes_next);
            if (!loop_cfg.limit_neg && loop_passes_next >= loop_cfg.limit) begin
              go = 1'b0;
            end
          end
          if (go) begin
            res_next.block_index = position_next;
            res_next.block_valid = 1'b1;
            step_pos = position_next + 1'b1;
            if (step_pos >= loop_cfg.last) begin
              position_next    = loop_cfg.first;
              loop_passes_next = sat_inc(loop_passes_next);
            end else begin
              position_next = step_pos;
            end
          end
        end else if (position < loop_cfg.total) begin
          res_next.block_index = position;
          res_next.block_valid = 1'b1;
          position_next        = position + 1'b1;
        end
      end
      OP_RELEASE: released_next = 1'b1;
      OP_SEEK: begin
        position_next = (in_item.seek_block > loop_cfg.total) ? loop_cfg.total
                                                              : in_item.seek_block;
      end
      default: begin
        position_next    = '0;
        loop_passes_next = '0;
        released_next    = 1'b0;
      end
    endcase
    looping_next = !released_next &&
                   (loop_cfg.limit_neg || loop_passes_next < loop_cfg.limit);
    res_next.play_done       = !looping_next && (position_next >= loop_cfg.total);
    res_next.loops_completed = loop_passes_next;
    res_next.released_flag   = released_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      res_valid   <= 1'b0;
      position    <= '0;
      loop_passes <= '0;
      released    <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        res_valid   <= 1'b1;
        position    <= position_next;
        loop_passes <= loop_passes_next;
        released    <= released_next;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req.payload;
    end
    if (advance) begin
      res_item <= res_next;
    end
  end

  `ASSERT_NEXT(a_advance_fills_result, clk, rst, advance, res_valid)
  `ASSERT_IMPL(a_block_in_sample, clk, rst, advance && res_next.block_valid, res_next.block_index < loop_cfg.total)

endmodule

@@ rtl/sample_loop_block_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_loop_block_sequencer
// Block address generator for looped sample playback.
// ----------------------------------------------------------------------------
// Every request (fetch, release, seek or restart) yields exactly one result.
// The block takes one request per cycle while no conversion runs and results
// are taken; a result passes through the request register, then the result
// register, and a second request is taken while a result waits at the
// output. A write to any loop register starts a conversion of the loop points
// from frames to blocks in a pair of bit-serial dividers (load, 26 quotient
// bits, clamp), during which requests are held off. Out of reset the loop
// points are ready at once.
// ----------------------------------------------------------------------------
module sample_loop_block_sequencer import slbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  slbs_req_if.sink              req,
  slbs_res_if.source            res
);

  loop_cfg_t loop_cfg;

  slbs_loop_unit u_loop_unit (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .loop_cfg  (loop_cfg)
  );

  slbs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .loop_cfg (loop_cfg),
    .req      (req),
    .res      (res)
  );

endmodule
